/* rtl/sfr_pkg.sv */
package sfr_pkg;

  // Default sizing
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int NUM_SYMBOLS_DEF = 256;

  // Operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Character constants
  localparam logic [7:0] CH_UPPER_A  = 8'd65;
  localparam logic [7:0] CH_UPPER_Z  = 8'd90;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_CR       = 8'd13;

  // Verdict of the ordering compare unit for one candidate bin
  typedef struct packed {
    logic nonzero;     // bin holds a count
    logic after_prev;  // sorts after the symbol chosen by the last pass
    logic beats_best;  // sorts before the best one seen so far in this pass
  } cmp_res_t;

  // One result of the block
  typedef struct packed {
    logic        found;
    logic [7:0]  symbol;
    logic [15:0] count;
    logic [8:0]  distinct;
  } res_t;

  // Space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  // Upper case letters fold to lower case
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    if ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

endpackage

/* rtl/sfr_ram.sv */
module sfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/sfr_order_cmp.sv */
module sfr_order_cmp #(
  parameter int COUNT_WIDTH = 16,
  parameter int SYM_W       = 8
) (
  input  logic [COUNT_WIDTH-1:0] cand_cnt,
  input  logic [SYM_W-1:0]       cand_sym,
  input  logic                   has_prev,
  input  logic [COUNT_WIDTH-1:0] prev_cnt,
  input  logic [SYM_W-1:0]       prev_sym,
  input  logic                   has_best,
  input  logic [COUNT_WIDTH-1:0] best_cnt,
  output sfr_pkg::cmp_res_t      res
);
  import sfr_pkg::*;

  // Order is count descending, then symbol ascending. Candidates arrive in
  // ascending symbol order, so an equal count never displaces the best.
  always_comb begin
    res.nonzero    = (cand_cnt != '0);
    res.after_prev = !has_prev || (cand_cnt < prev_cnt) ||
                     ((cand_cnt == prev_cnt) && (cand_sym > prev_sym));
    res.beats_best = !has_best || (cand_cnt > best_cnt);
  end

endmodule

/* rtl/symbol_frequency_ranker.sv */
// Channel  Direction  Handshake              Fields
// in_      request    in_valid / in_ready    operation, text_byte, wanted_rank
// out_     result     out_valid / out_ready  found, ranked_symbol, ranked_count,
//                                            distinct_symbols
//
// Add: bin read, then write back of the incremented count.
// Clear, skipped add, unranked query: answered from idle; valid bits are all cleared at once.
// Query: wanted_rank + 1 passes over all bins, one bin per cycle
//   through the shared ordering compare; each pass picks the next ranked symbol.
// Reset clears the valid bits, so the histogram reads as zero with no sweep.
// A finished result waits in a hold register while out_ready is low; no new
// request is taken until it has moved to the output register.
module symbol_frequency_ranker #(
  parameter int COUNT_WIDTH = sfr_pkg::COUNT_WIDTH_DEF,
  parameter int NUM_SYMBOLS = sfr_pkg::NUM_SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_text_byte,
  input  logic [7:0]  in_wanted_rank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [7:0]  out_ranked_symbol,
  output logic [15:0] out_ranked_count,
  output logic [8:0]  out_distinct_symbols
);
  import sfr_pkg::*;

  localparam int               SYM_W     = $clog2(NUM_SYMBOLS);
  localparam logic [SYM_W-1:0] LAST_SYM  = SYM_W'(NUM_SYMBOLS - 1);
  localparam logic [8:0]       SYM_LIMIT = 9'(NUM_SYMBOLS);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ADD_WR  = 5'b00010,
    ST_Q_SWEEP = 5'b00100,
    ST_Q_END   = 5'b01000,
    ST_HOLD    = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [SYM_W-1:0]       add_sym_r, add_sym_nxt;
  logic [7:0]             want_r, want_nxt;
  logic [7:0]             pass_r, pass_nxt;
  logic [SYM_W-1:0]       addr_r, addr_nxt;
  logic [SYM_W-1:0]       rd_sym_r;
  logic                   rd_vld_r;
  logic                   rd_live_r;
  logic [COUNT_WIDTH-1:0] prev_cnt_r, prev_cnt_nxt;
  logic [SYM_W-1:0]       prev_sym_r, prev_sym_nxt;
  logic                   has_prev_r, has_prev_nxt;
  logic [COUNT_WIDTH-1:0] best_cnt_r, best_cnt_nxt;
  logic [SYM_W-1:0]       best_sym_r, best_sym_nxt;
  logic                   has_best_r, has_best_nxt;
  logic [NUM_SYMBOLS-1:0] vld_r, vld_nxt;
  logic [8:0]             distinct_r, distinct_nxt;
  res_t                   hold_r, hold_nxt;
  res_t                   out_r;
  logic                   out_valid_r, out_valid_nxt;

  logic                   in_fire;
  logic [7:0]             folded;
  logic                   add_ok;
  logic [SYM_W-1:0]       rd_addr;
  logic                   rd_in_range;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] inc_cnt;
  logic                   wr_en;
  cmp_res_t               cmp;
  logic                   take;
  logic [COUNT_WIDTH-1:0] best_cnt_upd;
  logic [SYM_W-1:0]       best_sym_upd;
  logic                   has_best_upd;
  logic [COUNT_WIDTH+15:0] cnt_ext;
  logic                   done_now;
  res_t                   done_res;
  logic                   slot_free;
  logic                   out_load;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Byte preparation for an add
  assign folded = fold_case(in_text_byte);
  assign add_ok = !is_space(in_text_byte) && ({1'b0, folded} < SYM_LIMIT);

  // Read address: the incoming byte while idle, the sweep counter otherwise
  assign rd_addr     = (state_r == ST_IDLE) ? folded[SYM_W-1:0] : addr_r;
  assign rd_in_range = ({{(9 - SYM_W){1'b0}}, rd_addr} < SYM_LIMIT);

  sfr_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_SYMBOLS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (add_sym_r),
    .wr_data (inc_cnt),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Bins never written since the last clear read as zero
  assign cur_cnt = rd_vld_r ? rd_data : '0;
  assign inc_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
  assign wr_en   = (state_r == ST_ADD_WR);

  // Shared ordering compare, one bin per cycle
  sfr_order_cmp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SYM_W       (SYM_W)
  ) u_cmp (
    .cand_cnt (cur_cnt),
    .cand_sym (rd_sym_r),
    .has_prev (has_prev_r),
    .prev_cnt (prev_cnt_r),
    .prev_sym (prev_sym_r),
    .has_best (has_best_r),
    .best_cnt (best_cnt_r),
    .res      (cmp)
  );

  assign take         = rd_live_r && cmp.nonzero && cmp.after_prev && cmp.beats_best;
  assign best_cnt_upd = take ? cur_cnt : best_cnt_r;
  assign best_sym_upd = take ? rd_sym_r : best_sym_r;
  assign has_best_upd = take || has_best_r;
  assign cnt_ext      = {16'd0, best_cnt_upd};

  assign slot_free = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    add_sym_nxt   = add_sym_r;
    want_nxt      = want_r;
    pass_nxt      = pass_r;
    addr_nxt      = addr_r;
    prev_cnt_nxt  = prev_cnt_r;
    prev_sym_nxt  = prev_sym_r;
    has_prev_nxt  = has_prev_r;
    best_cnt_nxt  = best_cnt_upd;
    best_sym_nxt  = best_sym_upd;
    has_best_nxt  = has_best_upd;
    vld_nxt       = vld_r;
    distinct_nxt  = distinct_r;
    hold_nxt      = hold_r;
    done_now      = 1'b0;
    done_res      = '0;
    done_res.distinct = distinct_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_operation)
            OP_ADD: begin
              if (add_ok) begin
                add_sym_nxt = folded[SYM_W-1:0];
                state_nxt   = ST_ADD_WR;
              end else begin
                done_now = 1'b1;
              end
            end
            OP_QUERY: begin
              if ({1'b0, in_wanted_rank} >= distinct_r) begin
                done_now = 1'b1;
              end else begin
                want_nxt     = in_wanted_rank;
                pass_nxt     = '0;
                addr_nxt     = '0;
                has_prev_nxt = 1'b0;
                has_best_nxt = 1'b0;
                state_nxt    = ST_Q_SWEEP;
              end
            end
            OP_CLEAR: begin
              vld_nxt           = '0;
              distinct_nxt      = '0;
              done_now          = 1'b1;
              done_res.distinct = '0;
            end
            default: begin
              done_now = 1'b1;
            end
          endcase
        end
      end
      ST_ADD_WR: begin
        // write back happens through wr_en; first hit of a bin adds a symbol
        vld_nxt[add_sym_r] = 1'b1;
        if (cur_cnt == '0) begin
          distinct_nxt = distinct_r + 9'd1;
        end
        done_now          = 1'b1;
        done_res.distinct = distinct_nxt;
      end
      ST_Q_SWEEP: begin
        addr_nxt = addr_r + SYM_W'(1);
        if (addr_r == LAST_SYM) begin
          state_nxt = ST_Q_END;
        end
      end
      ST_Q_END: begin
        if (pass_r == want_r) begin
          done_now        = 1'b1;
          done_res.found  = 1'b1;
          done_res.symbol = 8'(best_sym_upd);
          done_res.count  = cnt_ext[15:0];
        end else begin
          // next pass starts after the symbol just ranked
          prev_cnt_nxt = best_cnt_upd;
          prev_sym_nxt = best_sym_upd;
          has_prev_nxt = 1'b1;
          has_best_nxt = 1'b0;
          pass_nxt     = pass_r + 8'd1;
          addr_nxt     = '0;
          state_nxt    = ST_Q_SWEEP;
        end
      end
      ST_HOLD: begin
        done_now = 1'b1;
        done_res = hold_r;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Hand the result over, or park it while the output is busy
    out_load = 1'b0;
    if (done_now) begin
      if (slot_free) begin
        out_load  = 1'b1;
        state_nxt = ST_IDLE;
      end else begin
        hold_nxt  = done_res;
        state_nxt = ST_HOLD;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      distinct_r  <= '0;
      out_valid_r <= 1'b0;
      rd_live_r   <= 1'b0;
      has_prev_r  <= 1'b0;
      has_best_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      distinct_r  <= distinct_nxt;
      out_valid_r <= out_valid_nxt;
      rd_live_r   <= (state_r == ST_Q_SWEEP);
      has_prev_r  <= has_prev_nxt;
      has_best_r  <= has_best_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    add_sym_r  <= add_sym_nxt;
    want_r     <= want_nxt;
    pass_r     <= pass_nxt;
    addr_r     <= addr_nxt;
    rd_sym_r   <= rd_addr;
    rd_vld_r   <= rd_in_range ? vld_r[rd_addr] : 1'b0;
    prev_cnt_r <= prev_cnt_nxt;
    prev_sym_r <= prev_sym_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_sym_r <= best_sym_nxt;
    hold_r     <= hold_nxt;
    if (out_load) begin
      out_r <= done_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_found            = out_r.found;
  assign out_ranked_symbol    = out_r.symbol;
  assign out_ranked_count     = out_r.count;
  assign out_distinct_symbols = out_r.distinct;

  // Checks
  a_distinct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    distinct_r <= SYM_LIMIT)
    else $error("distinct total beyond the number of bins");

  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Q_SWEEP) |-> (pass_r <= want_r))
    else $error("query pass counter ran past the wanted rank");

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_operation == OP_CLEAR)) |=> ((vld_r == '0) && (distinct_r == '0)))
    else $error("clear left a bin or the total set");

  a_add_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD_WR) |-> $past(in_valid && in_ready))
    else $error("bin write back without an accepted request");

  a_query_has_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Q_END) |-> (has_best_upd || (pass_r != want_r)))
    else $error("query finished a pass with no symbol chosen");

endmodule

/* dv/symbol_frequency_ranker_tb.sv */
module symbol_frequency_ranker_tb;
  import sfr_pkg::*;

  localparam logic [1:0]  OP_UNUSED       = 2'd3;
  localparam logic [7:0]  CH_LOWER_A      = 8'd97;
  localparam int unsigned COUNT_MAX       = (1 << COUNT_WIDTH_DEF) - 1;
  localparam int          RUN_LIMIT       = 4000000;
  localparam int          RANDOM_REQUESTS = 1240;
  localparam int          BURST_ADDS      = 40;
  localparam int          HOLD_OFF_CYCLES = 400;
  localparam int          SETTLE_CYCLES   = 20;
  localparam int          N_DIRECTED      = 25;
  localparam int          MAX_PRINTED     = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = OP_ADD;
  logic [7:0]  in_text_byte = '0;
  logic [7:0]  in_wanted_rank = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_found;
  logic [7:0]  out_ranked_symbol;
  logic [15:0] out_ranked_count;
  logic [8:0]  out_distinct_symbols;

  symbol_frequency_ranker dut (.*);

  always #6 clk = ~clk;

  // One directed request, with its answer typed in where it is obvious
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] text;
    logic [7:0] rank;
    logic       typed;
    res_t       want;
  } stim_row_t;

  localparam res_t NO_ANS = '0;

  stim_row_t directed_steps [N_DIRECTED] = '{
    '{OP_QUERY,  8'd0,   8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd0}},  // empty after reset
    '{OP_ADD,    8'd65,  8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd1}},  // 'A' folds to 'a'
    '{OP_ADD,    8'd97,  8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd1}},
    '{OP_ADD,    8'd90,  8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd2}},  // 'Z'
    '{OP_ADD,    8'd0,   8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd3}},
    '{OP_ADD,    8'd255, 8'd255, 1'b1, '{1'b0, 8'd0,   16'd0, 9'd4}},
    '{OP_ADD,    8'd32,  8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd4}},  // whitespace skipped
    '{OP_ADD,    8'd9,   8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd4}},
    '{OP_ADD,    8'd10,  8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd4}},
    '{OP_ADD,    8'd11,  8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd4}},
    '{OP_ADD,    8'd12,  8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd4}},
    '{OP_ADD,    8'd13,  8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd4}},
    '{OP_ADD,    8'd8,   8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd5}},  // just outside
    '{OP_ADD,    8'd14,  8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd6}},
    '{OP_ADD,    8'd64,  8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd7}},  // either side of A-Z
    '{OP_ADD,    8'd91,  8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd8}},
    '{OP_UNUSED, 8'd98,  8'd170, 1'b1, '{1'b0, 8'd0,   16'd0, 9'd8}},  // unused code
    '{OP_QUERY,  8'd0,   8'd0,   1'b1, '{1'b1, 8'd97,  16'd2, 9'd8}},
    '{OP_QUERY,  8'd0,   8'd1,   1'b1, '{1'b1, 8'd0,   16'd1, 9'd8}},  // tie, lowest symbol
    '{OP_QUERY,  8'd170, 8'd4,   1'b0, NO_ANS},
    '{OP_QUERY,  8'd0,   8'd7,   1'b1, '{1'b1, 8'd255, 16'd1, 9'd8}},  // last rank
    '{OP_QUERY,  8'd0,   8'd8,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd8}},  // one past the end
    '{OP_QUERY,  8'd0,   8'd255, 1'b1, '{1'b0, 8'd0,   16'd0, 9'd8}},
    '{OP_CLEAR,  8'd255, 8'd255, 1'b1, '{1'b0, 8'd0,   16'd0, 9'd0}},
    '{OP_QUERY,  8'd0,   8'd0,   1'b1, '{1'b0, 8'd0,   16'd0, 9'd0}}
  };

  // Histogram mirror and the answers still owed by the block
  int unsigned tally [NUM_SYMBOLS_DEF];
  int unsigned tally_distinct = 0;
  res_t        awaited_answers [$];

  int  n_errors = 0;
  int  n_checked = 0;
  int  n_cycles = 0;
  int  n_adds = 0;
  int  n_queries = 0;
  int  n_ranked = 0;
  int  n_clears = 0;
  int  full_distinct = 0;
  int  rx_hold_cycles = 0;
  bit  quiet_stretch = 1'b0;

  // Apply one request to the mirror and work out its answer
  function automatic res_t compute_answer(input logic [1:0] op, input logic [7:0] text,
                                          input logic [7:0] rank);
    res_t        ans;
    logic [7:0]  sym;
    int unsigned pos;
    ans = '0;
    case (op)
      OP_ADD: begin
        if (!(text == CH_SPACE || (text >= CH_TAB && text <= CH_CR))) begin
          sym = (text >= CH_UPPER_A && text <= CH_UPPER_Z) ? text + CASE_OFFSET : text;
          if (tally[sym] == 0) tally_distinct++;
          if (tally[sym] < COUNT_MAX) tally[sym]++;
        end
      end
      OP_QUERY: begin
        // rank of a bin: nonzero bins with a higher count, or equal count and lower symbol
        if (rank < tally_distinct) begin
          for (int i = 0; i < NUM_SYMBOLS_DEF; i++) begin
            if (tally[i] != 0 && !ans.found) begin
              pos = 0;
              for (int j = 0; j < NUM_SYMBOLS_DEF; j++) begin
                if (tally[j] != 0 &&
                    (tally[j] > tally[i] || (tally[j] == tally[i] && j < i))) pos++;
              end
              if (pos == rank) begin
                ans.found  = 1'b1;
                ans.symbol = 8'(i);
                ans.count  = 16'(tally[i]);
              end
            end
          end
        end
      end
      OP_CLEAR: begin
        foreach (tally[i]) tally[i] = 0;
        tally_distinct = 0;
      end
      default: ;
    endcase
    ans.distinct = 9'(tally_distinct);
    return ans;
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MAX_PRINTED) $display("ERROR cycle %0d: %s", n_cycles, what);
  endtask

  // Offer one request from a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [1:0] op, input logic [7:0] text,
                              input logic [7:0] rank, input bit typed = 1'b0,
                              input res_t typed_ans = '0);
    res_t ans;
    while (!quiet_stretch && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_text_byte   <= text;
    in_wanted_rank <= rank;
    do @(posedge clk); while (!in_ready);
    ans = compute_answer(op, text, rank);
    if (typed) ans = typed_ans;
    awaited_answers.insert(awaited_answers.size(), ans);
    case (op)
      OP_ADD:   n_adds++;
      OP_QUERY: begin
        n_queries++;
        if (ans.found) n_ranked++;
      end
      OP_CLEAR: n_clears++;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (awaited_answers.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) n_cycles++;

  // Result side: random stalls, a long hold-off on demand
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        rx_hold_cycles--;
      end else if (quiet_stretch) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // Compare each result with the oldest answer owed
  always @(posedge clk) begin : check_answers
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch($sformatf("result with none owed, symbol %0d count %0d",
                                  out_ranked_symbol, out_ranked_count));
      end else begin
        want = awaited_answers.pop_front();
        n_checked++;
        if (out_found !== want.found)
          report_mismatch($sformatf("result %0d found %b, want %b",
                                    n_checked, out_found, want.found));
        if (out_ranked_symbol !== want.symbol)
          report_mismatch($sformatf("result %0d symbol %0d, want %0d",
                                    n_checked, out_ranked_symbol, want.symbol));
        if (out_ranked_count !== want.count)
          report_mismatch($sformatf("result %0d count %0d, want %0d",
                                    n_checked, out_ranked_count, want.count));
        if (out_distinct_symbols !== want.distinct)
          report_mismatch($sformatf("result %0d distinct %0d, want %0d",
                                    n_checked, out_distinct_symbols, want.distinct));
      end
    end
  end

  // Watchdog
  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d answers still owed",
             RUN_LIMIT, awaited_answers.size());
    $display("symbol_frequency_ranker_tb NOT OK");
    $finish;
  end

  initial begin
    int         roll;
    int         sub;
    logic [1:0] op;
    logic [7:0] text;
    logic [7:0] rank;

    foreach (tally[i]) tally[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_steps[k]) begin
      send_request(directed_steps[k].op, directed_steps[k].text, directed_steps[k].rank,
                   directed_steps[k].typed, directed_steps[k].want);
    end

    // Burst of adds to one bin at full rate on both sides
    quiet_stretch = 1'b1;
    for (int n = 0; n < BURST_ADDS; n++) begin
      send_request(OP_ADD, n[0] ? CH_UPPER_A + 8'd4 : CH_LOWER_A + 8'd4, 8'(n));
    end
    repeat (3) send_request(OP_ADD, CH_LOWER_A + 8'd16, 8'd0);
    send_request(OP_QUERY, 8'd0, 8'd0);
    send_request(OP_QUERY, 8'd0, 8'd1);
    send_request(OP_QUERY, 8'd0, 8'd2);
    send_request(OP_ADD, CH_LOWER_A + 8'd4, 8'd0);
    send_request(OP_QUERY, 8'd0, 8'd0);
    quiet_stretch = 1'b0;

    // Every byte once: widest table the folding allows, then its deepest rank
    send_request(OP_CLEAR, 8'd0, 8'd0);
    for (int b = 0; b < 256; b++) send_request(OP_ADD, 8'(b), 8'($urandom_range(0, 255)));
    repeat (2) send_request(OP_ADD, CH_LOWER_A + 8'd23, 8'd0);
    full_distinct = tally_distinct;
    send_request(OP_QUERY, 8'd0, 8'(tally_distinct - 1));
    send_request(OP_QUERY, 8'd0, 8'(tally_distinct));
    send_request(OP_QUERY, 8'd0, 8'd0);

    // Receiver holds off while requests keep coming, then a full drain
    rx_hold_cycles = HOLD_OFF_CYCLES;
    repeat (30) send_request(OP_ADD, CH_LOWER_A + 8'($urandom_range(0, 25)), 8'd0);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    // Random text with occasional queries, clears and the unused code
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      quiet_stretch = (k >= 700 && k < 1000);
      roll = $urandom_range(0, 999);
      text = 8'($urandom_range(0, 255));
      rank = 8'($urandom_range(0, 255));
      if (roll < 10) begin
        op = OP_CLEAR;
      end else if (roll < 30) begin
        op = OP_UNUSED;
      end else if (roll < 190) begin
        op = OP_QUERY;
        sub = $urandom_range(0, 99);
        // deep ranks walk the whole table per rank, so keep most of them shallow
        if (sub < 80) begin
          rank = 8'($urandom_range(0, 3));
        end else if (sub < 92 && tally_distinct <= 48) begin
          rank = 8'(tally_distinct) - 8'($urandom_range(0, 1));
        end
      end else begin
        op = OP_ADD;
        sub = $urandom_range(0, 99);
        if (sub < 50) begin
          text = CH_LOWER_A + 8'($urandom_range(0, $urandom_range(0, 25)));
        end else if (sub < 65) begin
          text = CH_UPPER_A + 8'($urandom_range(0, 25));
        end else if (sub < 70) begin
          text = CH_SPACE;
        end else if (sub < 75) begin
          text = CH_TAB + 8'($urandom_range(0, 4));
        end
      end
      send_request(op, text, rank);
    end
    quiet_stretch = 1'b0;

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d adds, %0d queries (%0d ranked), %0d clears; %0d results checked",
             n_adds, n_queries, n_ranked, n_clears, n_checked);
    $display("Covered a %0d-add burst, a %0d-symbol table and a %0d-cycle output stall",
             BURST_ADDS, full_distinct, HOLD_OFF_CYCLES);
    if (n_errors == 0) begin
      $display("symbol_frequency_ranker_tb OK");
    end else begin
      $display("symbol_frequency_ranker_tb NOT OK");
    end
    $finish;
  end

endmodule
